### rtl/rap_pkg.sv
// shared types, constants and width helpers for the point rotation and projection block
package rap_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int GRID_W          = 12;
    localparam int HEIGHT_W        = 16;
    localparam int TRIG_W          = 16;
    localparam int SCALE_W         = 20;
    localparam int SCREEN_W        = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_ADDR_W      = 3;
    localparam int FRAC            = 14;
    localparam int ISO_K           = 14189;
    localparam int ISO_X_SHIFT     = 24;
    localparam int ISO_Y_SHIFT     = 25;
    localparam int PAR_SHIFT       = 10;
    localparam int ISO_X_ROUND     = (1 << ISO_X_SHIFT) - 1;
    localparam int ISO_Y_ROUND     = (1 << ISO_Y_SHIFT) - 1;
    localparam int PAR_ROUND       = (1 << PAR_SHIFT) - 1;
    localparam int CLAMP_W         = 18;
    localparam int CLAMP_HI        = (1 << (CLAMP_W - 1)) - 1;
    localparam int CLAMP_LO        = -(1 << (CLAMP_W - 1));
    localparam int SCREEN_HI       = (1 << (SCREEN_W - 1)) - 1;
    localparam int SCREEN_LO       = -(1 << (SCREEN_W - 1));
    localparam int ROT_STAGES      = 7;
    localparam int PROJ_STAGES     = 5;
    localparam int NUM_STAGES      = ROT_STAGES + PROJ_STAGES;

    localparam logic [CFG_DATA_W-1:0] ROT_RESET   = 32'h4000_0000;
    localparam logic [SCALE_W-1:0]    ZOOM_RESET  = 20'd1024;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE   = 3'd0,
        REG_ROT_X  = 3'd1,
        REG_ROT_Y  = 3'd2,
        REG_ROT_Z  = 3'd3,
        REG_ZOOM   = 3'd4,
        REG_HSCALE = 3'd5,
        REG_OFF_X  = 3'd6,
        REG_OFF_Y  = 3'd7
    } rap_reg_t;

    typedef struct packed {
        logic                       mode;
        logic [CFG_DATA_W-1:0]      rot_x;
        logic [CFG_DATA_W-1:0]      rot_y;
        logic [CFG_DATA_W-1:0]      rot_z;
        logic [SCALE_W-1:0]         zoom;
        logic [SCALE_W-1:0]         hscale;
        logic signed [SCREEN_W-1:0] off_x;
        logic signed [SCREEN_W-1:0] off_y;
    } rap_cfg_t;

    function automatic int rap_imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int rap_cw(int coord_width);
        return (coord_width < GRID_W) ? coord_width : GRID_W;
    endfunction

    function automatic int rap_x1w(int coord_width);
        return rap_cw(coord_width) + TRIG_W + 2;
    endfunction

    function automatic int rap_y2w(int coord_width);
        return rap_imax(rap_x1w(coord_width) + TRIG_W, HEIGHT_W + TRIG_W + FRAC) + 1 - FRAC;
    endfunction

    function automatic int rap_x3w(int coord_width);
        return rap_imax(rap_x1w(coord_width) + TRIG_W, rap_y2w(coord_width) + TRIG_W)
            + 1 - FRAC;
    endfunction

    function automatic int rap_dw(int coord_width);
        return rap_imax(rap_x3w(coord_width), rap_y2w(coord_width)) + 1;
    endfunction

endpackage

### rtl/rotate_and_project_point.sv
// top level: config registers, stage handshake and the rotation and projection pipeline
//
// grid points arrive on the s_axis channel, one transaction per point, and each
// gives exactly one screen position on the m_axis channel, in arrival order.
// m_axis_tuser carries the clip flag, set when either coordinate saturated.
// the pipeline has twelve register stages, and a point accepted on s_axis passes
// through each of them in order before it shows on m_axis.
// throughput is one point per cycle while the output is not stalled;
// each stage holds one multiply or one wide add.
// every stage has its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and the input keeps taking points while a
// result waits on a stalled receiver, until all twelve stages are full.
// a stall never drops or repeats a transaction.
// configuration is written through cfg_we, cfg_addr and cfg_wdata, by the user only
// while the pipeline is empty (not enforced by the block); there is no read-back.
// reset empties the pipeline and sets the registers to an identity rotation,
// unit zoom, zero height scale, zero offsets and isometric mode.
module rotate_and_project_point
    import rap_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // grid_col, grid_row, height
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // screen_x, screen_y
    output logic                  m_axis_tuser,  // clipped
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DW  = rap_dw(COORD_WIDTH);
    localparam int X3W = rap_x3w(COORD_WIDTH);

    rap_cfg_t cfg_reg, cfg_next;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   stage_rdy;

    logic [GRID_W-1:0]          grid_col, grid_row, col_r, row_r;
    logic signed [HEIGHT_W-1:0] height, height_r;
    logic signed [DW-1:0]       diff, sum;
    logic signed [X3W-1:0]      z3;
    logic signed [SCREEN_W-1:0] screen_x, screen_y;
    logic                       clipped;

    assign grid_col = s_axis_tdata[GRID_W-1:0];
    assign grid_row = s_axis_tdata[2*GRID_W-1:GRID_W];
    assign height   = $signed(s_axis_tdata[2*GRID_W+HEIGHT_W-1:2*GRID_W]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rap_reg_t'(cfg_addr))
                REG_MODE:   cfg_next.mode   = cfg_wdata[0];
                REG_ROT_X:  cfg_next.rot_x  = cfg_wdata;
                REG_ROT_Y:  cfg_next.rot_y  = cfg_wdata;
                REG_ROT_Z:  cfg_next.rot_z  = cfg_wdata;
                REG_ZOOM:   cfg_next.zoom   = cfg_wdata[SCALE_W-1:0];
                REG_HSCALE: cfg_next.hscale = cfg_wdata[SCALE_W-1:0];
                REG_OFF_X:  cfg_next.off_x  = $signed(cfg_wdata[SCREEN_W-1:0]);
                REG_OFF_Y:  cfg_next.off_y  = $signed(cfg_wdata[SCREEN_W-1:0]);
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= 1'b0;
            cfg_reg.rot_x  <= ROT_RESET;
            cfg_reg.rot_y  <= ROT_RESET;
            cfg_reg.rot_z  <= ROT_RESET;
            cfg_reg.zoom   <= ZOOM_RESET;
            cfg_reg.hscale <= '0;
            cfg_reg.off_x  <= '0;
            cfg_reg.off_y  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        stage_rdy[NUM_STAGES] = m_axis_tready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (stage_rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    rap_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .clk        (clk),
        .cfg        (cfg_reg),
        .en         (stage_rdy[ROT_STAGES-1:0]),
        .grid_col   (grid_col),
        .grid_row   (grid_row),
        .height     (height),
        .diff       (diff),
        .sum        (sum),
        .z3         (z3),
        .col_out    (col_r),
        .row_out    (row_r),
        .height_out (height_r)
    );

    rap_project #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_project (
        .clk      (clk),
        .cfg      (cfg_reg),
        .en       (stage_rdy[NUM_STAGES-1:ROT_STAGES]),
        .diff     (diff),
        .sum      (sum),
        .z3       (z3),
        .col      (col_r),
        .row      (row_r),
        .height   (height_r),
        .screen_x (screen_x),
        .screen_y (screen_y),
        .clipped  (clipped)
    );

    assign s_axis_tready = stage_rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {screen_y, screen_x};
    assign m_axis_tuser  = clipped;

endmodule

### rtl/rap_rotate.sv
// euler rotation stages: z, then x, then y, ending in the iso sum and difference
module rap_rotate
    import rap_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  rap_cfg_t                               cfg,
    input  logic [ROT_STAGES-1:0]                  en,
    input  logic [GRID_W-1:0]                      grid_col,
    input  logic [GRID_W-1:0]                      grid_row,
    input  logic signed [HEIGHT_W-1:0]             height,
    output logic signed [rap_dw(COORD_WIDTH)-1:0]  diff,
    output logic signed [rap_dw(COORD_WIDTH)-1:0]  sum,
    output logic signed [rap_x3w(COORD_WIDTH)-1:0] z3,
    output logic [GRID_W-1:0]                      col_out,
    output logic [GRID_W-1:0]                      row_out,
    output logic signed [HEIGHT_W-1:0]             height_out
);

    localparam int CW  = rap_cw(COORD_WIDTH);
    localparam int PZ  = CW + TRIG_W + 1;
    localparam int PH  = HEIGHT_W + TRIG_W;
    localparam int X1W = rap_x1w(COORD_WIDTH);
    localparam int M1  = X1W + TRIG_W;
    localparam int T1  = rap_imax(M1, PH + FRAC) + 1;
    localparam int Y2W = rap_y2w(COORD_WIDTH);
    localparam int M2  = Y2W + TRIG_W;
    localparam int T2  = rap_imax(M1, M2) + 1;
    localparam int X3W = rap_x3w(COORD_WIDTH);
    localparam int DW  = rap_dw(COORD_WIDTH);

    logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;
    logic signed [CW:0]       col_s, row_s;

    logic [GRID_W-1:0]          col_reg    [ROT_STAGES];
    logic [GRID_W-1:0]          row_reg    [ROT_STAGES];
    logic signed [HEIGHT_W-1:0] height_reg [ROT_STAGES];

    // stage 1
    logic signed [PZ-1:0] col_cz_reg, row_sz_reg, col_sz_reg, row_cz_reg;
    logic signed [PH-1:0] h_sx1_reg, h_cx1_reg;
    // stage 2
    logic signed [X1W-1:0] x1_2_reg, y1_2_reg;
    logic signed [PH-1:0]  h_sx2_reg, h_cx2_reg;
    // stage 3
    logic signed [M1-1:0]  y1_cx_reg, y1_sx_reg;
    logic signed [PH-1:0]  h_sx3_reg, h_cx3_reg;
    logic signed [X1W-1:0] x1_3_reg;
    // stage 4
    logic signed [T1-1:0]  y2_next, z2_next;
    logic signed [Y2W-1:0] y2_4_reg, z2_4_reg;
    logic signed [X1W-1:0] x1_4_reg;
    // stage 5
    logic signed [M1-1:0]  x1_cy_reg, x1_sy_reg;
    logic signed [M2-1:0]  z2_sy_reg, z2_cy_reg;
    logic signed [Y2W-1:0] y2_5_reg;
    // stage 6
    logic signed [T2-1:0]  x3_next, z3_next;
    logic signed [X3W-1:0] x3_6_reg, z3_6_reg;
    logic signed [Y2W-1:0] y2_6_reg;
    // stage 7
    logic signed [DW-1:0]  diff_reg, sum_reg;
    logic signed [X3W-1:0] z3_7_reg;

    always_comb
    begin
        cx    = $signed(cfg.rot_x[CFG_DATA_W-1:TRIG_W]);
        sx    = $signed(cfg.rot_x[TRIG_W-1:0]);
        cy    = $signed(cfg.rot_y[CFG_DATA_W-1:TRIG_W]);
        sy    = $signed(cfg.rot_y[TRIG_W-1:0]);
        cz    = $signed(cfg.rot_z[CFG_DATA_W-1:TRIG_W]);
        sz    = $signed(cfg.rot_z[TRIG_W-1:0]);
        col_s = $signed({1'b0, grid_col[CW-1:0]});
        row_s = $signed({1'b0, grid_row[CW-1:0]});

        y2_next = T1'(y1_cx_reg) - (T1'(h_sx3_reg) <<< FRAC);
        z2_next = T1'(y1_sx_reg) + (T1'(h_cx3_reg) <<< FRAC);
        x3_next = T2'(x1_cy_reg) + T2'(z2_sy_reg);
        z3_next = T2'(z2_cy_reg) - T2'(x1_sy_reg);
    end

    // input fields travel alongside for the parallel path
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            col_reg[0]    <= GRID_W'(grid_col[CW-1:0]);
            row_reg[0]    <= GRID_W'(grid_row[CW-1:0]);
            height_reg[0] <= height;
        end
        for (int i = 1; i < ROT_STAGES; i++)
        begin
            if (en[i])
            begin
                col_reg[i]    <= col_reg[i-1];
                row_reg[i]    <= row_reg[i-1];
                height_reg[i] <= height_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            col_cz_reg <= PZ'(col_s) * PZ'(cz);
            row_sz_reg <= PZ'(row_s) * PZ'(sz);
            col_sz_reg <= PZ'(col_s) * PZ'(sz);
            row_cz_reg <= PZ'(row_s) * PZ'(cz);
            h_sx1_reg  <= PH'(height) * PH'(sx);
            h_cx1_reg  <= PH'(height) * PH'(cx);
        end
        if (en[1])
        begin
            x1_2_reg  <= X1W'(col_cz_reg) - X1W'(row_sz_reg);
            y1_2_reg  <= X1W'(col_sz_reg) + X1W'(row_cz_reg);
            h_sx2_reg <= h_sx1_reg;
            h_cx2_reg <= h_cx1_reg;
        end
        if (en[2])
        begin
            y1_cx_reg <= M1'(y1_2_reg) * M1'(cx);
            y1_sx_reg <= M1'(y1_2_reg) * M1'(sx);
            h_sx3_reg <= h_sx2_reg;
            h_cx3_reg <= h_cx2_reg;
            x1_3_reg  <= x1_2_reg;
        end
        if (en[3])
        begin
            y2_4_reg <= y2_next[T1-1:FRAC];
            z2_4_reg <= z2_next[T1-1:FRAC];
            x1_4_reg <= x1_3_reg;
        end
        if (en[4])
        begin
            x1_cy_reg <= M1'(x1_4_reg) * M1'(cy);
            x1_sy_reg <= M1'(x1_4_reg) * M1'(sy);
            z2_sy_reg <= M2'(z2_4_reg) * M2'(sy);
            z2_cy_reg <= M2'(z2_4_reg) * M2'(cy);
            y2_5_reg  <= y2_4_reg;
        end
        if (en[5])
        begin
            x3_6_reg <= x3_next[T2-1:FRAC];
            z3_6_reg <= z3_next[T2-1:FRAC];
            y2_6_reg <= y2_5_reg;
        end
        if (en[6])
        begin
            diff_reg <= DW'(x3_6_reg) - DW'(y2_6_reg);
            sum_reg  <= DW'(x3_6_reg) + DW'(y2_6_reg);
            z3_7_reg <= z3_6_reg;
        end
    end

    assign diff       = diff_reg;
    assign sum        = sum_reg;
    assign z3         = z3_7_reg;
    assign col_out    = col_reg[ROT_STAGES-1];
    assign row_out    = row_reg[ROT_STAGES-1];
    assign height_out = height_reg[ROT_STAGES-1];

endmodule

### rtl/rap_project.sv
// projection, zoom and height scaling, truncation, offsets and saturation stages
module rap_project
    import rap_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  rap_cfg_t                               cfg,
    input  logic [PROJ_STAGES-1:0]                 en,
    input  logic signed [rap_dw(COORD_WIDTH)-1:0]  diff,
    input  logic signed [rap_dw(COORD_WIDTH)-1:0]  sum,
    input  logic signed [rap_x3w(COORD_WIDTH)-1:0] z3,
    input  logic [GRID_W-1:0]                      col,
    input  logic [GRID_W-1:0]                      row,
    input  logic signed [HEIGHT_W-1:0]             height,
    output logic signed [SCREEN_W-1:0]             screen_x,
    output logic signed [SCREEN_W-1:0]             screen_y,
    output logic                                   clipped
);

    localparam int DW   = rap_dw(COORD_WIDTH);
    localparam int X3W  = rap_x3w(COORD_WIDTH);
    localparam int ZSW  = SCALE_W + 1;
    localparam int KW   = FRAC + 2;
    localparam int MDW  = DW + KW;
    localparam int MSW  = DW + ZSW;
    localparam int MZW  = X3W + ZSW;
    localparam int DXW  = MDW - FRAC;
    localparam int EYW  = rap_imax(MSW, MZW + 1) + 1;
    localparam int PDW  = DXW + ZSW;
    localparam int PCW  = GRID_W + SCALE_W;
    localparam int PHW  = HEIGHT_W + ZSW;
    localparam int PBW  = rap_imax(PCW + 1, PHW) + 1;
    localparam int PAW  = PCW - PAR_SHIFT;
    localparam int W11  = rap_imax(rap_imax(PDW - ISO_X_SHIFT, EYW - ISO_Y_SHIFT),
                                   rap_imax(PAW + 1, PBW - PAR_SHIFT));
    localparam int SUMW = CLAMP_W + 1;

    localparam logic signed [W11-1:0]  CL_HI = W11'(CLAMP_HI);
    localparam logic signed [W11-1:0]  CL_LO = W11'(CLAMP_LO);
    localparam logic signed [SUMW-1:0] SC_HI = SUMW'(SCREEN_HI);
    localparam logic signed [SUMW-1:0] SC_LO = SUMW'(SCREEN_LO);

    logic signed [ZSW-1:0] zoom_s, hs_s;

    // stage 8
    logic signed [MDW-1:0] md_reg;
    logic signed [MSW-1:0] ms_reg;
    logic signed [MZW-1:0] mz_reg;
    logic [PCW-1:0]        pc_reg, pr_reg;
    logic signed [PHW-1:0] phh_reg;
    // stage 9
    logic signed [DXW-1:0] dx_reg;
    logic signed [EYW-1:0] ey9_reg;
    logic [PCW-1:0]        pa9_reg;
    logic signed [PBW-1:0] pb9_reg;
    // stage 10
    logic signed [PDW-1:0] pdx_reg;
    logic signed [EYW-1:0] ey_reg;
    logic [PCW-1:0]        pa_reg;
    logic signed [PBW-1:0] pb_reg;
    // stage 11
    logic signed [PDW-1:0]     pdx_adj;
    logic signed [EYW-1:0]     ey_adj;
    logic signed [PBW-1:0]     pb_adj;
    logic signed [W11-1:0]     px_sel, py_sel;
    logic signed [CLAMP_W-1:0] px_next, py_next;
    logic signed [CLAMP_W-1:0] px_reg, py_reg;
    // stage 12
    logic signed [SUMW-1:0]     sx_sum, sy_sum;
    logic signed [SCREEN_W-1:0] screen_x_next, screen_y_next;
    logic                       clipped_next;
    logic signed [SCREEN_W-1:0] screen_x_reg, screen_y_reg;
    logic                       clipped_reg;

    always_comb
    begin
        zoom_s = $signed({1'b0, cfg.zoom});
        hs_s   = $signed({1'b0, cfg.hscale});

        // division by a power of two, truncated toward zero
        pdx_adj = pdx_reg + (pdx_reg[PDW-1] ? PDW'(ISO_X_ROUND) : PDW'(0));
        ey_adj  = ey_reg + (ey_reg[EYW-1] ? EYW'(ISO_Y_ROUND) : EYW'(0));
        pb_adj  = pb_reg + (pb_reg[PBW-1] ? PBW'(PAR_ROUND) : PBW'(0));

        if (cfg.mode)
        begin
            px_sel = W11'($signed({1'b0, pa_reg[PCW-1:PAR_SHIFT]}));
            py_sel = W11'($signed(pb_adj[PBW-1:PAR_SHIFT]));
        end
        else
        begin
            px_sel = W11'($signed(pdx_adj[PDW-1:ISO_X_SHIFT]));
            py_sel = W11'($signed(ey_adj[EYW-1:ISO_Y_SHIFT]));
        end

        // pre-clamp keeps the offset add narrow without changing the saturation outcome
        if (px_sel > CL_HI)
            px_next = CLAMP_W'(CL_HI);
        else if (px_sel < CL_LO)
            px_next = CLAMP_W'(CL_LO);
        else
            px_next = CLAMP_W'(px_sel);

        if (py_sel > CL_HI)
            py_next = CLAMP_W'(CL_HI);
        else if (py_sel < CL_LO)
            py_next = CLAMP_W'(CL_LO);
        else
            py_next = CLAMP_W'(py_sel);

        sx_sum       = SUMW'(px_reg) + SUMW'(cfg.off_x);
        sy_sum       = SUMW'(py_reg) + SUMW'(cfg.off_y);
        clipped_next = 1'b0;

        if (sx_sum > SC_HI)
        begin
            screen_x_next = SCREEN_W'(SC_HI);
            clipped_next  = 1'b1;
        end
        else if (sx_sum < SC_LO)
        begin
            screen_x_next = SCREEN_W'(SC_LO);
            clipped_next  = 1'b1;
        end
        else
        begin
            screen_x_next = SCREEN_W'(sx_sum);
        end

        if (sy_sum > SC_HI)
        begin
            screen_y_next = SCREEN_W'(SC_HI);
            clipped_next  = 1'b1;
        end
        else if (sy_sum < SC_LO)
        begin
            screen_y_next = SCREEN_W'(SC_LO);
            clipped_next  = 1'b1;
        end
        else
        begin
            screen_y_next = SCREEN_W'(sy_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            md_reg  <= MDW'(diff) * MDW'(ISO_K);
            ms_reg  <= MSW'(sum) * MSW'(zoom_s);
            mz_reg  <= MZW'(z3) * MZW'(hs_s);
            pc_reg  <= PCW'(col) * PCW'(cfg.zoom);
            pr_reg  <= PCW'(row) * PCW'(cfg.zoom);
            phh_reg <= PHW'(height) * PHW'(hs_s);
        end
        if (en[1])
        begin
            dx_reg  <= md_reg[MDW-1:FRAC];
            ey9_reg <= EYW'(ms_reg) - (EYW'(mz_reg) <<< 1);
            pa9_reg <= pc_reg;
            pb9_reg <= PBW'($signed({1'b0, pr_reg})) - PBW'(phh_reg);
        end
        if (en[2])
        begin
            pdx_reg <= PDW'(dx_reg) * PDW'(zoom_s);
            ey_reg  <= ey9_reg;
            pa_reg  <= pa9_reg;
            pb_reg  <= pb9_reg;
        end
        if (en[3])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (en[4])
        begin
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;
    assign clipped  = clipped_reg;

endmodule

### tb/tb_rotate_and_project_point.sv
// testbench for the grid point rotation and screen projection block
`timescale 1ns / 1ps

module tb_rotate_and_project_point;
    import rap_pkg::*;

    localparam int          DRAIN_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          RAND_PHASES   = 12;
    localparam int          PHASE_POINTS  = 50;
    localparam int          Q14           = 14;
    localparam longint      ISO_COS30     = 14189;
    localparam int          MAX_REPORTS   = 40;

    typedef struct {
        logic [GRID_W-1:0]          col;
        logic [GRID_W-1:0]          row;
        logic signed [HEIGHT_W-1:0] height;
    } grid_point_t;

    typedef struct {
        logic signed [SCREEN_W-1:0] x;
        logic signed [SCREEN_W-1:0] y;
        logic                       clip;
    } screen_point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_we = 1'b0;
    rap_reg_t              cfg_addr = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rap_cfg_t      active_cfg;
    grid_point_t   pending_points[$];
    screen_point_t expected_screen[$];
    grid_point_t   offered_point;
    logic          idle_on = 1'b1;
    logic          hold_req = 1'b0;
    logic          hold_done = 1'b0;
    int            hold_left = 0;
    int            error_count = 0;
    int unsigned   cycle_count = 0;

    rotate_and_project_point uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic longint toward_zero(longint v, int n);
        return (v >= 0) ? (v >>> n) : -((-v) >>> n);
    endfunction

    function automatic logic out_of_range(longint v);
        return (v > SCREEN_HI) || (v < SCREEN_LO);
    endfunction

    function automatic logic [SCREEN_W-1:0] clamp_screen(longint v);
        if (v > SCREEN_HI)
        begin
            return 16'h7FFF;
        end
        if (v < SCREEN_LO)
        begin
            return 16'h8000;
        end
        return v[SCREEN_W-1:0];
    endfunction

    function automatic screen_point_t project_point(rap_cfg_t c, grid_point_t p);
        longint col, row, hgt, zm, hs;
        longint cx, sx, cy, sy, cz, sz;
        longint x1, y1, z0, y2, z2, x3, z3, dx, px, py;
        screen_point_t r;
        col = p.col;
        row = p.row;
        hgt = p.height;
        zm  = c.zoom;
        hs  = c.hscale;
        if (c.mode)
        begin
            px = toward_zero(col * zm, 10);
            py = toward_zero(row * zm - hgt * hs, 10);
        end
        else
        begin
            cx = $signed(c.rot_x[31:16]);
            sx = $signed(c.rot_x[15:0]);
            cy = $signed(c.rot_y[31:16]);
            sy = $signed(c.rot_y[15:0]);
            cz = $signed(c.rot_z[31:16]);
            sz = $signed(c.rot_z[15:0]);
            // about z exact, then x and y floored back to q14
            x1 = col * cz - row * sz;
            y1 = col * sz + row * cz;
            z0 = hgt * 16384;
            y2 = (y1 * cx - z0 * sx) >>> Q14;
            z2 = (y1 * sx + z0 * cx) >>> Q14;
            x3 = (x1 * cy + z2 * sy) >>> Q14;
            z3 = (z2 * cy - x1 * sy) >>> Q14;
            dx = ((x3 - y2) * ISO_COS30) >>> Q14;
            px = toward_zero(dx * zm, 24);
            py = toward_zero((x3 + y2) * zm - 2 * z3 * hs, 25);
        end
        px = px + longint'($signed(c.off_x));
        py = py + longint'($signed(c.off_y));
        r.x    = clamp_screen(px);
        r.y    = clamp_screen(py);
        r.clip = out_of_range(px) || out_of_range(py);
        return r;
    endfunction

    function automatic logic [31:0] pick_trig();
        logic [15:0] c, s;
        case ($urandom_range(0, 3))
            0: return $urandom();
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_7FFF;
                    1: return 32'h8000_8000;
                    2: return 32'h8000_7FFF;
                    default: return 32'h7FFF_8000;
                endcase
            end
            default:
            begin
                c = 16'($urandom_range(0, 32768) - 16384);
                s = 16'($urandom_range(0, 32768) - 16384);
                return {c, s};
            end
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 3))
            0: return SCALE_W'($urandom_range(0, 4096));
            1: return SCALE_W'($urandom_range(0, 20'hFFFFF));
            2: return $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
            default: return 20'd1024;
        endcase
    endfunction

    function automatic logic [SCREEN_W-1:0] pick_offset();
        case ($urandom_range(0, 3))
            0: return SCREEN_W'($urandom());
            1: return SCREEN_W'($urandom_range(0, 512) - 256);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'h0;
        endcase
    endfunction

    function automatic logic [GRID_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 12'd0;
            1: return 12'd4095;
            default: return GRID_W'($urandom());
        endcase
    endfunction

    function automatic grid_point_t random_point();
        grid_point_t p;
        p.col = pick_coord();
        p.row = pick_coord();
        case ($urandom_range(0, 7))
            0: p.height = 16'sh7FFF;
            1: p.height = 16'sh8000;
            2, 3: p.height = HEIGHT_W'($urandom_range(0, 600) - 300);
            default: p.height = HEIGHT_W'($urandom());
        endcase
        return p;
    endfunction

    task automatic queue_point(int col, int row, int height);
        grid_point_t p;
        p.col    = GRID_W'(col);
        p.row    = GRID_W'(row);
        p.height = HEIGHT_W'(height);
        pending_points.push_back(p);
    endtask

    // sampled away from the active edge so the driver's updates have settled
    task automatic wait_idle();
        while (pending_points.size() != 0 || s_axis_tvalid || expected_screen.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(rap_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    task automatic set_projection(input logic m, input logic [31:0] rx, ry, rz,
                                  input logic [SCALE_W-1:0] zm, hs,
                                  input logic [SCREEN_W-1:0] ox, oy);
        write_reg(REG_MODE, {31'b0, m});
        write_reg(REG_ROT_X, rx);
        write_reg(REG_ROT_Y, ry);
        write_reg(REG_ROT_Z, rz);
        write_reg(REG_ZOOM, {12'b0, zm});
        write_reg(REG_HSCALE, {12'b0, hs});
        write_reg(REG_OFF_X, {16'b0, ox});
        write_reg(REG_OFF_Y, {16'b0, oy});
        @(posedge clk);
        cfg_we <= 1'b0;
        active_cfg.mode   = m;
        active_cfg.rot_x  = rx;
        active_cfg.rot_y  = ry;
        active_cfg.rot_z  = rz;
        active_cfg.zoom   = zm;
        active_cfg.hscale = hs;
        active_cfg.off_x  = ox;
        active_cfg.off_y  = oy;
    endtask

    // driver: offers queued points, records the expectation on each transaction
    always @(posedge clk or negedge rst_n)
    begin : point_driver
        grid_point_t next_pt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_screen.push_back(project_point(active_cfg, offered_point));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_points.size() != 0 && !(idle_on && $urandom_range(0, 99) < 26))
                begin
                    next_pt = pending_points.pop_front();
                    offered_point <= next_pt;
                    s_axis_tdata  <= {next_pt.height, next_pt.row, next_pt.col};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction and drives the ready side
    always @(posedge clk or negedge rst_n)
    begin : screen_monitor
        screen_point_t want;
        logic signed [SCREEN_W-1:0] got_x, got_y;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_x = m_axis_tdata[15:0];
                got_y = m_axis_tdata[31:16];
                if (expected_screen.size() == 0)
                begin
                    error_count <= error_count + 1;
                    if (error_count < MAX_REPORTS)
                    begin
                        $display("%0t unexpected: expected none, got x %0d y %0d clip %0b",
                                 $time, got_x, got_y, m_axis_tuser);
                    end
                end
                else
                begin
                    want = expected_screen.pop_front();
                    if (want.x !== got_x || want.y !== got_y || want.clip !== m_axis_tuser)
                    begin
                        error_count <= error_count + 1;
                        if (error_count < MAX_REPORTS)
                        begin
                            $display(
                                "%0t mismatch: expected %0d,%0d clip %0b, got %0d,%0d clip %0b",
                                $time, want.x, want.y, want.clip,
                                got_x, got_y, m_axis_tuser);
                        end
                    end
                end
            end
            if (hold_req && !hold_done)
            begin
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 26);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        active_cfg.mode   = 1'b0;
        active_cfg.rot_x  = ROT_RESET;
        active_cfg.rot_y  = ROT_RESET;
        active_cfg.rot_z  = ROT_RESET;
        active_cfg.zoom   = ZOOM_RESET;
        active_cfg.hscale = '0;
        active_cfg.off_x  = '0;
        active_cfg.off_y  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity rotation, unit zoom
        queue_point(0, 0, 0);
        queue_point(4095, 0, 32767);
        queue_point(0, 4095, -32768);
        queue_point(4095, 4095, -1);
        queue_point(1, 0, 1);
        queue_point(0, 1, -1);
        wait_idle();

        // trig values beyond one, full scales, offsets at the bounds
        set_projection(1'b0, 32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000,
                       20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h8000);
        queue_point(4095, 4095, 32767);
        queue_point(0, 0, -32768);
        queue_point(4095, 0, 0);
        queue_point(2048, 2048, -32768);
        wait_idle();

        // parallel mode, saturation both ways
        set_projection(1'b1, ROT_RESET, ROT_RESET, ROT_RESET,
                       20'hFFFFF, 20'hFFFFF, 16'h0, 16'h0);
        queue_point(4095, 4095, -32768);
        queue_point(0, 0, 32767);
        queue_point(4095, 0, -1);
        wait_idle();

        set_projection(1'b1, ROT_RESET, ROT_RESET, ROT_RESET,
                       20'h0, 20'h0, 16'h8000, 16'h7FFF);
        queue_point(123, 456, 789);
        queue_point(4095, 4095, -32768);
        wait_idle();

        // fractional height scale, truncation toward zero
        set_projection(1'b1, ROT_RESET, ROT_RESET, ROT_RESET,
                       20'd1024, 20'd1536, 16'h0, 16'h0);
        queue_point(0, 0, 1);
        queue_point(0, 0, -1);
        queue_point(3, 0, 5);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_projection(1'($urandom_range(0, 1)), pick_trig(), pick_trig(), pick_trig(),
                           pick_scale(), pick_scale(), pick_offset(), pick_offset());
            idle_on  <= (p != 3);
            hold_req <= (p == 5);
            for (int i = 0; i < PHASE_POINTS; i++)
            begin
                pending_points.push_back(random_point());
            end
            wait_idle();
        end

        if (error_count == 0 && expected_screen.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### rotate_and_project_point.f
rtl/rap_pkg.sv
rtl/rap_rotate.sv
rtl/rap_project.sv
rtl/rotate_and_project_point.sv
tb/tb_rotate_and_project_point.sv
